>>> rtl/keypad_press_classifier_assert.svh
// Assertion macros shared by the keypad press classifier modules.
`ifndef KEYPAD_PRESS_CLASSIFIER_ASSERT_SVH
`define KEYPAD_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define KPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define KPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kpc_pkg.sv
// Shared types and constants for the keypad press classifier.
package kpc_pkg;

    // Field widths
    localparam int KEY_W      = 4;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int KEY_EXT_W  = 6;   // holds any key count up to 32
    localparam int IN_TDATA_W = 40;  // 37 bits of fields, padded to bytes
    localparam int OUT_TDATA_W = 40; // 36 bits of fields, padded to bytes
    localparam int OUT_TUSER_W = 2;

    // Default keypad layout
    localparam int NUM_KEYS_DEF = 10;
    localparam int STAR_KEY_DEF = 8;

    // Result queue depth, a power of two
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SHORT = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_LONG  = 1'd1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] MIN_SHORT_RST = 16'd50;
    localparam logic [CFG_W-1:0] MIN_LONG_RST  = 16'd800;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_STAR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        kind_t             kind;
        logic [TIME_W-1:0] held;
    } event_t;

endpackage

>>> rtl/kpc_front.sv
// Front end: per-key state update and release classification.
module kpc_front #(
    parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEF,
    parameter int STAR_KEY = kpc_pkg::STAR_KEY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [kpc_pkg::KEY_W-1:0]      key_index,
    input  logic                           key_level,
    input  logic [kpc_pkg::TIME_W-1:0]     now_ms,
    input  logic                           cfg_wr_en,
    input  logic [kpc_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [kpc_pkg::CFG_W-1:0]      cfg_data,
    output logic                           res_valid,
    output kpc_pkg::event_t                res
);

    localparam int  IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam bit  HAS_STAR = (STAR_KEY < NUM_KEYS);
    localparam int  STAR_IDX = HAS_STAR ? STAR_KEY : 0;

    logic [NUM_KEYS-1:0]               key_down_reg;
    logic [NUM_KEYS-1:0]               key_down_next;
    logic                              star_used_reg;
    logic                              star_used_next;
    logic [kpc_pkg::TIME_W-1:0]        press_start_reg [NUM_KEYS];
    logic [kpc_pkg::CFG_W-1:0]         min_short_reg;
    logic [kpc_pkg::CFG_W-1:0]         min_long_reg;

    logic [kpc_pkg::KEY_EXT_W-1:0]     key_ext;
    logic [IDX_W-1:0]                  idx;
    logic                              in_range;
    logic                              is_star;
    logic                              star_down;
    logic                              change;
    logic                              suppress;
    logic                              bounce;
    logic                              star_combo;
    logic [kpc_pkg::TIME_W-1:0]        held;
    kpc_pkg::kind_t                    kind;

    // Decode the key and look up its state
    always_comb
    begin
        key_ext    = kpc_pkg::KEY_EXT_W'(key_index);
        in_range   = key_ext < kpc_pkg::KEY_EXT_W'(NUM_KEYS);
        idx        = key_ext[IDX_W-1:0];
        is_star    = HAS_STAR && (key_ext == kpc_pkg::KEY_EXT_W'(STAR_KEY));
        star_down  = HAS_STAR && key_down_reg[STAR_IDX];
        change     = in_valid && in_range && (key_down_reg[idx] != key_level);
        suppress   = is_star && star_used_reg;
        held       = now_ms - press_start_reg[idx];
        bounce     = held < kpc_pkg::TIME_W'(min_short_reg);
        star_combo = star_down && !is_star;
    end

    // Classify the release
    always_comb
    begin
        if (star_combo)
        begin
            kind = kpc_pkg::KIND_STAR;
        end
        else if (held > kpc_pkg::TIME_W'(min_long_reg))
        begin
            kind = kpc_pkg::KIND_LONG;
        end
        else
        begin
            kind = kpc_pkg::KIND_SHORT;
        end
        res_valid = change && !key_level && !suppress && !bounce;
        res.key   = key_index;
        res.kind  = kind;
        res.held  = held;
    end

    // Next key-down flags and modifier flag
    always_comb
    begin
        key_down_next  = key_down_reg;
        star_used_next = star_used_reg;
        if (change)
        begin
            key_down_next[idx] = key_level;
        end
        if (change && !key_level && suppress)
        begin
            star_used_next = 1'b0;
        end
        else if (res_valid && star_combo)
        begin
            star_used_next = 1'b1;
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg  <= '0;
            star_used_reg <= 1'b0;
            min_short_reg <= kpc_pkg::MIN_SHORT_RST;
            min_long_reg  <= kpc_pkg::MIN_LONG_RST;
        end
        else
        begin
            key_down_reg  <= key_down_next;
            star_used_reg <= star_used_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    kpc_pkg::REG_MIN_SHORT: min_short_reg <= cfg_data;
                    kpc_pkg::REG_MIN_LONG:  min_long_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Record the press start time
    always_ff @(posedge clk)
    begin
        if (change && key_level)
        begin
            press_start_reg[idx] <= now_ms;
        end
    end

`include "keypad_press_classifier_assert.svh"

    `KPC_ASSERT_NXT(a_star_sets_flag, res_valid && (res.kind == kpc_pkg::KIND_STAR), star_used_reg, "star combination did not mark star as used")
    `KPC_ASSERT_IMP(a_press_silent, in_valid && key_level, !res_valid, "press produced a result")
    `KPC_ASSERT_IMP(a_bad_key_silent, in_valid && !in_range, !res_valid, "bad key gave a result")

endmodule

>>> rtl/kpc_queue.sv
// Back end: result queue that drives the output stream.
module kpc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kpc_pkg::event_t  push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output kpc_pkg::event_t  out_data
);

    localparam int DEPTH = kpc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    kpc_pkg::event_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    // Flags and head entry
    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        out_valid = (count_reg != '0);
        out_data  = entry_reg[rd_ptr_reg];
        pop       = out_valid && out_ready;
    end

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // Hold pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a new result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "keypad_press_classifier_assert.svh"

    `KPC_ASSERT_IMP(a_no_overflow, push, count_reg != CNT_W'(DEPTH), "push into a full result queue")
    `KPC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "result queue count out of range")
    `KPC_ASSERT_NXT(a_pop_drains, pop && !push, count_reg == $past(count_reg) - CNT_W'(1), "pop did not drain the queue")

endmodule

>>> rtl/keypad_press_classifier.sv
// Each result is stored in the result queue when its input request is taken and is offered behind older results.
// Throughput: one input request per cycle; input stalls only when the 4-entry
// result queue between the classifier and the output is full.
// Per-key state updates by a read-modify-write at acceptance.
// Reset (async, active low) releases all keys, clears the star modifier flag and
// the queue, and loads 50 ms / 800 ms thresholds; press start times are not cleared.
module keypad_press_classifier #(
    parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEF,
    parameter int STAR_KEY = kpc_pkg::STAR_KEY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // key_index[3:0], key_level[4], now_ms[36:5], zero pad
    input  logic [kpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // event_key[3:0], held_ms[35:4], zero pad
    output logic [kpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // event_kind[1:0]
    output logic [kpc_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    input  logic                               cfg_wr_en,
    input  logic [kpc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [kpc_pkg::CFG_W-1:0]          cfg_data
);

    logic             queue_full;
    logic             in_accept;
    logic             res_valid;
    kpc_pkg::event_t  res;
    kpc_pkg::event_t  out_event;

    // Take a request whenever the queue has room
    assign s_axis_tready = !queue_full;
    assign in_accept     = s_axis_tvalid && !queue_full;

    kpc_front #(
        .NUM_KEYS (NUM_KEYS),
        .STAR_KEY (STAR_KEY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept),
        .key_index (s_axis_tdata[3:0]),
        .key_level (s_axis_tdata[4]),
        .now_ms    (s_axis_tdata[36:5]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    kpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (queue_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_event)
    );

    // Pack the output stream
    assign m_axis_tdata = {4'b0000, out_event.held, out_event.key};
    assign m_axis_tuser = kpc_pkg::OUT_TUSER_W'(out_event.kind);

endmodule

>>> test/keypad_press_classifier_tb.sv
// Self-checking stream testbench for the keypad press classifier.
module keypad_press_classifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS       = kpc_pkg::NUM_KEYS_DEF;
    localparam int STAR_IDX    = kpc_pkg::STAR_KEY_DEF;
    localparam int PHASE_ITEMS = 125;
    localparam int STALL_LIMIT = 5000;

    // Predicts press events from key samples and checks the block's output.
    class press_scoreboard;
        localparam int KEYS = kpc_pkg::NUM_KEYS_DEF;
        localparam int STAR = kpc_pkg::STAR_KEY_DEF;

        logic                       key_down   [KEYS];
        logic [kpc_pkg::TIME_W-1:0] press_time [KEYS];
        logic                       star_modifier;
        logic [kpc_pkg::CFG_W-1:0]  short_limit;
        logic [kpc_pkg::CFG_W-1:0]  long_limit;
        kpc_pkg::event_t            pending_events [$];
        int unsigned                errors;

        function new();
            for (int i = 0; i < KEYS; i++)
            begin
                key_down[i]   = 1'b0;
                press_time[i] = '0;
            end
            star_modifier = 1'b0;
            short_limit   = kpc_pkg::MIN_SHORT_RST;
            long_limit    = kpc_pkg::MIN_LONG_RST;
            errors        = 0;
        endfunction

        function void set_thresholds(logic [kpc_pkg::CFG_W-1:0] short_ms,
                                     logic [kpc_pkg::CFG_W-1:0] long_ms);
            short_limit = short_ms;
            long_limit  = long_ms;
        endfunction

        // Apply one accepted sample and queue the event it causes, if any.
        function void note_request(logic [kpc_pkg::KEY_W-1:0] key, logic level,
                                   logic [kpc_pkg::TIME_W-1:0] now);
            logic [kpc_pkg::TIME_W-1:0] held;
            kpc_pkg::event_t            ev;
            if (key >= KEYS)
                return;
            if (key_down[key] == level)
                return;
            key_down[key] = level;
            if (level)
            begin
                press_time[key] = now;
                return;
            end
            // star was consumed as a modifier: swallow its own release
            if (key == STAR && star_modifier)
            begin
                star_modifier = 1'b0;
                return;
            end
            held = now - press_time[key];
            if (held < {16'd0, short_limit})
                return;
            ev.key  = key;
            ev.held = held;
            if (STAR < KEYS && key_down[STAR] && key != STAR)
            begin
                star_modifier = 1'b1;
                ev.kind       = kpc_pkg::KIND_STAR;
            end
            else if (held > {16'd0, long_limit})
                ev.kind = kpc_pkg::KIND_LONG;
            else
                ev.kind = kpc_pkg::KIND_SHORT;
            pending_events.push_back(ev);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted event with the oldest prediction.
        task check_event(logic [kpc_pkg::KEY_W-1:0] key, logic [1:0] kind,
                         logic [kpc_pkg::TIME_W-1:0] held);
            kpc_pkg::event_t want;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event key %0d kind %0d held %0d",
                                          key, kind, held));
                return;
            end
            want = pending_events.pop_front();
            if (key !== want.key)
                report_mismatch($sformatf("event_key %0d, want %0d", key, want.key));
            if (kind !== want.kind)
                report_mismatch($sformatf("event_kind %0d, want %0d (key %0d)",
                                          kind, want.kind, want.key));
            if (held !== want.held)
                report_mismatch($sformatf("held_ms %0d, want %0d (key %0d)",
                                          held, want.held, want.key));
        endtask
    endclass

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [kpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    logic [kpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [kpc_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic                            cfg_wr_en     = 1'b0;
    logic [kpc_pkg::REG_IDX_W-1:0]   cfg_index     = kpc_pkg::REG_MIN_SHORT;
    logic [kpc_pkg::CFG_W-1:0]       cfg_data      = '0;

    press_scoreboard            sb;
    int unsigned                idle_cycles;
    bit                         quiet     = 1'b0;
    bit                         send_gaps = 1'b1;
    logic [kpc_pkg::CFG_W-1:0]  cur_short = kpc_pkg::MIN_SHORT_RST;
    logic [kpc_pkg::CFG_W-1:0]  cur_long  = kpc_pkg::MIN_LONG_RST;
    logic                       gen_down  [NKEYS];
    logic [kpc_pkg::TIME_W-1:0] gen_start [NKEYS];
    logic [kpc_pkg::TIME_W-1:0] time_base = '0;

    keypad_press_classifier i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check results, then note accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_event(m_axis_tdata[3:0], m_axis_tuser, m_axis_tdata[35:4]);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[3:0], s_axis_tdata[4], s_axis_tdata[36:5]);
        end
    end

    // Count cycles with no traffic on any port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                 || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Stall the result side in bursts; hold ready high once quiet
    initial
    begin : ready_driver
        int run;
        wait (rst_n);
        forever
        begin
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                m_axis_tready <= 1'b1;
                run = $urandom_range(1, 60);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                run = $urandom_range(1, 19);
            end
            repeat (run) @(posedge clk);
        end
    end

    // Offer one request and hold it until taken; track key state for stimulus
    task automatic send_sample(input logic [kpc_pkg::KEY_W-1:0] key, input logic level,
                               input logic [kpc_pkg::TIME_W-1:0] now);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, now, level, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (key < NKEYS && gen_down[key] != level)
        begin
            gen_down[key] = level;
            if (level)
                gen_start[key] = now;
        end
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet && send_gaps && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every predicted event is out and the pipeline is empty
    task automatic drain_events();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_thresholds(input logic [kpc_pkg::CFG_W-1:0] short_ms,
                                    input logic [kpc_pkg::CFG_W-1:0] long_ms);
        cfg_wr_en <= 1'b1;
        cfg_index <= kpc_pkg::REG_MIN_SHORT;
        cfg_data  <= short_ms;
        @(posedge clk);
        cfg_index <= kpc_pkg::REG_MIN_LONG;
        cfg_data  <= long_ms;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_thresholds(short_ms, long_ms);
        cur_short = short_ms;
        cur_long  = long_ms;
    endtask

    // Pick one sample: mostly clean press/release pairs, some noise
    task automatic send_random_sample(output bit effective);
        logic [kpc_pkg::KEY_W-1:0]  key;
        logic                       level;
        logic [kpc_pkg::TIME_W-1:0] now;
        logic [kpc_pkg::TIME_W-1:0] held;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            key = kpc_pkg::KEY_W'($urandom_range(NKEYS, 15));
        else if (pick < 22)
            key = kpc_pkg::KEY_W'(STAR_IDX);
        else
            key = kpc_pkg::KEY_W'($urandom_range(0, NKEYS - 1));
        effective = 1'b0;
        if (key >= NKEYS)
        begin
            level = 1'($urandom_range(0, 1));
            now   = $urandom();
        end
        else if ($urandom_range(0, 99) < 12)
        begin
            // repeat the current level: must change nothing
            level = gen_down[key];
            now   = $urandom();
        end
        else if (!gen_down[key])
        begin
            level     = 1'b1;
            effective = 1'b1;
            if ($urandom_range(0, 9) < 3)
                now = $urandom();
            else
            begin
                time_base = time_base + $urandom_range(0, 3000);
                now       = time_base;
            end
        end
        else
        begin
            level     = 1'b0;
            effective = 1'b1;
            case ($urandom_range(0, 9))
                0:       held = $urandom_range(0, cur_short);
                1:       held = kpc_pkg::TIME_W'(cur_short);
                2:       held = (cur_short > 0) ? cur_short - 1 : 0;
                3:       held = kpc_pkg::TIME_W'(cur_long);
                4:       held = cur_long + 1;
                5, 6:    held = $urandom_range(cur_short, cur_long);
                7:       held = $urandom_range(cur_long, cur_long + 5000);
                8:       held = $urandom();
                default: held = $urandom_range(0, 2000);
            endcase
            now = gen_start[key] + held;
        end
        send_sample(key, level, now);
    endtask

    // Reset, directed corner cases, then random phases under several thresholds
    initial
    begin : stimulus
        logic [kpc_pkg::CFG_W-1:0] phase_short [6];
        logic [kpc_pkg::CFG_W-1:0] phase_long  [6];
        int                        made;
        bit                        effective;
        sb = new();
        for (int i = 0; i < NKEYS; i++)
        begin
            gen_down[i]  = 1'b0;
            gen_start[i] = '0;
        end
        phase_short = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd50};
        phase_long  = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd800};
        phase_short[4] = kpc_pkg::CFG_W'($urandom_range(0, 400));
        phase_long[4]  = kpc_pkg::CFG_W'($urandom_range(0, 3000));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keys outside the keypad and a release of a key that is up
        send_sample(4'd10, 1'b1, 32'd100);
        send_sample(4'd15, 1'b1, 32'hFFFF_FFFF);
        send_sample(4'd2, 1'b0, 32'd7);
        // press time wraps across zero
        send_sample(4'd0, 1'b1, 32'hFFFF_FF00);
        send_sample(4'd0, 1'b0, 32'h0000_0010);
        // repeated press keeps the first start time, long press
        send_sample(4'd1, 1'b1, 32'd1000);
        send_sample(4'd1, 1'b1, 32'd2000);
        send_sample(4'd1, 1'b0, 32'd1801);
        // bounce, then exactly the short threshold
        send_sample(4'd3, 1'b1, 32'd5000);
        send_sample(4'd3, 1'b0, 32'd5049);
        send_sample(4'd3, 1'b1, 32'd6000);
        send_sample(4'd3, 1'b0, 32'd6050);
        // exactly the long threshold stays short
        send_sample(4'd4, 1'b1, 32'd7000);
        send_sample(4'd4, 1'b0, 32'd7800);
        // star combination, then the star release is swallowed
        send_sample(4'(STAR_IDX), 1'b1, 32'd10000);
        send_sample(4'd9, 1'b1, 32'd10100);
        send_sample(4'd9, 1'b0, 32'd10300);
        send_sample(4'(STAR_IDX), 1'b0, 32'd10310);
        // swallowed star release even when it would be bounce
        send_sample(4'(STAR_IDX), 1'b1, 32'd20000);
        send_sample(4'd5, 1'b1, 32'd20001);
        send_sample(4'd5, 1'b0, 32'd20100);
        send_sample(4'(STAR_IDX), 1'b0, 32'd20010);
        // bounce under star does not arm the modifier
        send_sample(4'(STAR_IDX), 1'b1, 32'd30000);
        send_sample(4'd6, 1'b1, 32'd30000);
        send_sample(4'd6, 1'b0, 32'd30020);
        send_sample(4'(STAR_IDX), 1'b0, 32'd31000);
        // largest held time
        send_sample(4'd7, 1'b1, 32'd1);
        send_sample(4'd7, 1'b0, 32'd0);

        for (int p = 0; p < 6; p++)
        begin
            drain_events();
            write_thresholds(phase_short[p], phase_long[p]);
            if (p == 5)
                quiet = 1'b1;
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_gaps = !send_gaps;
                sender_gap();
                send_random_sample(effective);
                if (effective)
                    made++;
            end
        end

        drain_events();
        repeat (6) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
